@@ hdl/bcc_pkg.sv @@
// shared types and constants for the button click classifier
// no dependencies; used by bcc_classify and button_click_classifier_top

package bcc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned StampWidth = 16;
   localparam int unsigned DebWidth   = 8;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_LONG   = 2'd3
   } kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_LONG_PRESS   = 2'd0,
      REG_DOUBLE_CLICK = 2'd1,
      REG_DEBOUNCE     = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_idx_type;

   localparam logic [StampWidth-1:0] LongPressReset   = 16'd500;
   localparam logic [StampWidth-1:0] DoubleClickReset = 16'd300;
   localparam logic [DebWidth-1:0]   DebounceReset    = 8'd20;

   typedef struct packed {
      logic [StampWidth-1:0] long_press_ms;
      logic [StampWidth-1:0] double_click_ms;
      logic [DebWidth-1:0]   debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic                  last_level;
      logic [1:0]            press_count;
      logic [TimeWidth-1:0]  last_accept_time;
      logic [StampWidth-1:0] press_time;
      logic [StampWidth-1:0] prior_press_time;
      logic [StampWidth-1:0] press_gap;
   } state_type;

   localparam state_type StateReset = '{
      last_level:       1'b1,
      press_count:      2'd0,
      last_accept_time: '0,
      press_time:       '0,
      prior_press_time: '0,
      press_gap:        '0
   };

endpackage

@@ hdl/bcc_classify.sv @@
// next-state and click classification for one button sample
// depends on bcc_pkg

module bcc_classify (
   input  logic                            button_level,
   input  logic [bcc_pkg::TimeWidth-1:0]   now_ms,
   input  bcc_pkg::cfg_type                cfg,
   input  bcc_pkg::state_type              state_cur,
   output bcc_pkg::state_type              state_next,
   output bcc_pkg::kind_type               click_kind
);

   logic [bcc_pkg::TimeWidth-1:0]  since_accept;
   logic                           debounce_ok;
   logic [bcc_pkg::StampWidth-1:0] now_stamp;
   logic [bcc_pkg::StampWidth-1:0] elapsed;
   logic                           single_hit;
   logic                           double_hit;
   logic                           long_hit;
   bcc_pkg::state_type             upd;

   assign now_stamp    = now_ms[bcc_pkg::StampWidth-1:0];
   assign since_accept = now_ms - state_cur.last_accept_time;
   assign debounce_ok  = since_accept >
                         {{(bcc_pkg::TimeWidth-bcc_pkg::DebWidth){1'b0}}, cfg.debounce_ms};

   always_comb begin
      upd = state_cur;
      if (!button_level) begin
         if (debounce_ok) begin
            upd.last_accept_time = now_ms;
            if (state_cur.last_level) begin
               upd.press_time = now_stamp;
               if (state_cur.press_count != 2'd0) begin
                  upd.press_gap = now_stamp - state_cur.prior_press_time;
               end
               upd.prior_press_time = now_stamp;
               upd.press_count      = state_cur.press_count + 2'd1;
            end
            upd.last_level = 1'b0;
         end
      end else begin
         upd.last_level = 1'b1;
      end
   end

   // elapsed uses the press time as updated by this sample
   assign elapsed = now_stamp - upd.press_time;

   assign single_hit = upd.last_level && (upd.press_count == 2'd1) &&
                       (elapsed < cfg.long_press_ms) && (elapsed >= cfg.double_click_ms);
   assign double_hit = upd.last_level && (upd.press_count == 2'd2) &&
                       (upd.press_gap < cfg.double_click_ms);
   assign long_hit   = upd.last_level && (upd.press_count == 2'd1) &&
                       (elapsed >= cfg.long_press_ms);

   always_comb begin
      state_next = upd;
      click_kind = bcc_pkg::KIND_NONE;
      priority if (single_hit) begin
         state_next.press_count = 2'd0;
         click_kind             = bcc_pkg::KIND_SINGLE;
      end else if (double_hit) begin
         state_next.press_count = 2'd0;
         click_kind             = bcc_pkg::KIND_DOUBLE;
      end else if (long_hit) begin
         state_next.press_count = 2'd0;
         click_kind             = bcc_pkg::KIND_LONG;
      end else begin
         click_kind = bcc_pkg::KIND_NONE;
      end
   end

endmodule

@@ hdl/button_click_classifier_top.sv @@
// top level of the button click classifier: input stage, state, result stage
// depends on bcc_pkg and bcc_classify
//
// usage:
//   req channel carries one sample: req_button_level (0 pressed) and req_now_ms.
//   rsp channel returns exactly one rsp_click_kind per sample, in order
//   (0 none, 1 single, 2 double, 3 long press).
//   csr channel writes long_press_ms (index 0), double_click_ms (index 1) and
//   debounce_ms (index 2) from csr_data; other indexes are dropped. csr_ready
//   is always high; write only while the block is idle.
// result: an accepted sample's result is written to the result register once the
//   result stage is free or drained, and rsp shows it from that register.
// throughput: one sample per cycle while the result stage is free or drained;
//   the state update of one sample is a single combinational pass (a 32-bit
//   debounce subtract and compare, then 16-bit elapsed subtract and compares)
//   between the input register and the state and result registers, so the
//   next sample sees the updated state.
// reset: state returns to released with no pending presses, registers to their
//   defaults, both stages empty.
// stall: while rsp_ready is low the result holds; the input stage still takes
//   one more sample, then req_ready drops until the result is taken.

module button_click_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_button_level,
   input  logic [bcc_pkg::TimeWidth-1:0]      req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_click_kind,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bcc_pkg::CsrDataWidth-1:0]   csr_data
);

   logic                          in_vld_ff;
   logic                          in_level_ff;
   logic [bcc_pkg::TimeWidth-1:0] in_now_ff;
   logic                          out_vld_ff;
   bcc_pkg::kind_type             out_kind_ff;
   bcc_pkg::kind_type             kind_in;
   bcc_pkg::state_type            state_ff;
   bcc_pkg::state_type            state_in;
   bcc_pkg::cfg_type              cfg_ff;
   logic                          advance;
   bcc_pkg::reg_idx_type          csr_sel;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_sel   = bcc_pkg::reg_idx_type'(csr_index);

   bcc_classify u_classify (
      .button_level (in_level_ff),
      .now_ms       (in_now_ff),
      .cfg          (cfg_ff),
      .state_cur    (state_ff),
      .state_next   (state_in),
      .click_kind   (kind_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= bcc_pkg::StateReset;
         cfg_ff     <= '{long_press_ms:   bcc_pkg::LongPressReset,
                         double_click_ms: bcc_pkg::DoubleClickReset,
                         debounce_ms:     bcc_pkg::DebounceReset};
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_sel)
               bcc_pkg::REG_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_data;
               bcc_pkg::REG_DOUBLE_CLICK: cfg_ff.double_click_ms <= csr_data;
               bcc_pkg::REG_DEBOUNCE: begin
                  cfg_ff.debounce_ms <= csr_data[bcc_pkg::DebWidth-1:0];
               end
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff <= req_button_level;
         in_now_ff   <= req_now_ms;
      end
      if (advance) begin
         out_kind_ff <= kind_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_click_kind = out_kind_ff;

endmodule

@@ hdl/bcc_checker.sv @@
// port-level checks for the button click classifier, bound to the top level
// depends on button_click_classifier_top port names

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_click_kind,
   input logic       csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_click_kind))
      else $error("result changed while stalled");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // with the result stage empty the input side must take an item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   // item taken under a stall fills the input stage, so a continued stall blocks input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(req_valid && req_ready) && $past(rsp_valid && !rsp_ready)
      && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted with both stages full");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_click_kind (rsp_click_kind),
   .csr_ready      (csr_ready)
);
